// ===== hdl/sha2_pkg.sv =====
// Shared types, constants and functions of the SHA-2 hash engine.
// No dependencies; used by the controller, the datapath and the top level.
package sha2_pkg;

	localparam logic [1:0] VarSha224 = 2'd0;
	localparam logic [1:0] VarSha256 = 2'd1;
	localparam logic [1:0] VarSha384 = 2'd2;
	localparam logic [1:0] VarSha512 = 2'd3;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_ROUND = 7'b0000100,
		ST_ADD   = 7'b0001000,
		ST_PAD   = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_INIT  = 7'b1000000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       init;        // reload initial values, clear counters
		logic       put_byte;    // write put_val at fill, bump fill
		logic [7:0] put_val;
		logic       count_add;   // add valid bytes of the item to the count
		logic [3:0] count_n;
		logic       load;        // copy chain into working vars, round 0
		logic       round;       // one compression round
		logic       add;         // fold working vars into chain, fill 0
	} cmd_t;

	typedef struct packed {
		logic       wide;
		logic [6:0] fill;
		logic       block_full;  // a byte written at fill completes the block
		logic       last_round;
		logic [6:0] stop;
	} stat_t;

	localparam logic [63:0] RK [80] = '{
	64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
	64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
	64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
	64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
	64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
	64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
	64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
	64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
	64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
	64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
	64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
	64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
	64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
	64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
	64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
	64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
	64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
	64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
	64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
	64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};

	localparam logic [63:0] IV512 [8] = '{
	64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
	64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};
	localparam logic [63:0] IV384 [8] = '{
	64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17, 64'h152FECD8F70E5939,
	64'h67332667FFC00B31, 64'h8EB44A8768581511, 64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4};

	function automatic logic [63:0] init_value(input logic [1:0] v, input logic [2:0] i);
		logic [63:0] r;
		case (v)
			VarSha224: r = {32'd0, IV384[i][31:0]};
			VarSha256: r = {32'd0, IV512[i][63:32]};
			VarSha384: r = IV384[i];
			default:   r = IV512[i];
		endcase
		return r;
	endfunction

	function automatic logic [3:0] digest_words(input logic [1:0] v);
		logic [3:0] r;
		case (v)
			VarSha224: r = 4'd7;
			VarSha384: r = 4'd6;
			default:   r = 4'd8;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/sha2_datapath.sv =====
// Datapath of the SHA-2 engine: block buffer, message schedule, round
// registers, chaining value and byte counter. Uses sha2_pkg.
module sha2_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        variant,
	input  sha2_pkg::cmd_t    cmd,
	input  logic [2:0]        rd_index,
	output sha2_pkg::stat_t   stat,
	output logic [127:0]      byte_count,
	output logic [63:0]       rd_word
);

	logic [63:0] chain_q [8];
	logic [63:0] wv_q [8];
	logic [63:0] sched_q [16];
	logic [6:0]  fill_q;
	logic [6:0]  round_q;
	logic [127:0] count_q;
	logic        wide;

	assign wide = variant[1];

	// Schedule words as the rounds see them: sched_q[0] is W[t] in either width.
	// For the narrow modes 32-bit words live in the low halves after loading.
	logic [63:0] w0, w1, w9, w14, s0, s1, wnext;
	logic [63:0] k_t, t1, t2, ch, maj, sig0, sig1, a, e;

	always_comb begin
		w0  = sched_q[0];
		w1  = sched_q[1];
		w9  = sched_q[9];
		w14 = sched_q[14];
		a   = wv_q[0];
		e   = wv_q[4];
		if (wide) begin
			s0   = {w1[0], w1[63:1]} ^ {w1[7:0], w1[63:8]} ^ (w1 >> 7);
			s1   = {w14[18:0], w14[63:19]} ^ {w14[60:0], w14[63:61]} ^ (w14 >> 6);
			sig1 = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
			sig0 = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
			k_t  = sha2_pkg::RK[round_q];
		end else begin
			s0   = {32'd0, {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1[31:0] >> 3)};
			s1   = {32'd0, {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]}
				^ (w14[31:0] >> 10)};
			sig1 = {32'd0, {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]}};
			sig0 = {32'd0, {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]}};
			k_t  = {32'd0, sha2_pkg::RK[round_q[6:0]][63:32]};
		end
		wnext = s1 + w9 + s0 + w0;
		ch    = wv_q[6] ^ (e & (wv_q[5] ^ wv_q[6]));
		maj   = (a & wv_q[1]) | (wv_q[2] & (a | wv_q[1]));
		t1    = wv_q[7] + sig1 + ch + k_t + w0;
		t2    = sig0 + maj;
		if (!wide) begin
			wnext[63:32] = 32'd0;
			t1[63:32]    = 32'd0;
			t2[63:32]    = 32'd0;
		end
	end

	logic [63:0] new_a, new_e;
	always_comb begin
		new_a = t1 + t2;
		new_e = wv_q[3] + t1;
		if (!wide) begin
			new_a[63:32] = 32'd0;
			new_e[63:32] = 32'd0;
		end
	end

	// Byte write position within the buffer.
	logic [3:0] wr_entry;
	logic [5:0] wr_shift;
	assign wr_entry = fill_q[6:3];
	assign wr_shift = 6'd56 - {fill_q[2:0], 3'b000};

	always_ff @(posedge clk) begin
		if (cmd.put_byte) begin
			sched_q[wr_entry] <= (sched_q[wr_entry] & ~(64'hFF << wr_shift))
				| ({56'd0, cmd.put_val} << wr_shift);
		end else if (cmd.load) begin
			// Narrow modes unpack eight buffer entries into sixteen 32-bit words.
			if (!wide) begin
				for (int i = 0; i < 8; i++) begin
					sched_q[2 * i]     <= {32'd0, sched_q[i][63:32]};
					sched_q[2 * i + 1] <= {32'd0, sched_q[i][31:0]};
				end
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i + 1];
			sched_q[15] <= wnext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha2_pkg::init_value(sha2_pkg::VarSha256, 3'(i));
				wv_q[i]    <= '0;
			end
			fill_q  <= '0;
			round_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.init) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= sha2_pkg::init_value(variant, 3'(i));
				fill_q  <= '0;
				count_q <= '0;
			end else begin
				if (cmd.put_byte) fill_q <= fill_q + 7'd1;
				if (cmd.count_add) count_q <= count_q + {124'd0, cmd.count_n};
			end
			if (cmd.load) begin
				for (int i = 0; i < 8; i++) wv_q[i] <= chain_q[i];
				round_q <= '0;
			end
			if (cmd.round) begin
				wv_q[7] <= wv_q[6]; wv_q[6] <= wv_q[5]; wv_q[5] <= wv_q[4];
				wv_q[4] <= new_e;
				wv_q[3] <= wv_q[2]; wv_q[2] <= wv_q[1]; wv_q[1] <= wv_q[0];
				wv_q[0] <= new_a;
				round_q <= round_q + 7'd1;
			end
			if (cmd.add) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= wide ? chain_q[i] + wv_q[i]
						: {32'd0, chain_q[i][31:0] + wv_q[i][31:0]};
				end
				fill_q  <= '0;
				round_q <= '0;
			end
		end
	end

	assign stat.wide       = wide;
	assign stat.fill       = fill_q;
	assign stat.block_full = wide ? (fill_q == 7'd127) : (fill_q == 7'd63);
	assign stat.last_round = wide ? (round_q == 7'd79) : (round_q == 7'd63);
	assign stat.stop       = wide ? 7'd112 : 7'd56;
	assign byte_count      = count_q;
	assign rd_word         = chain_q[rd_index];

endmodule

// ===== hdl/sha2_control.sv =====
// Controller of the SHA-2 engine: sequences byte insertion, padding,
// compression rounds and digest output. Uses sha2_pkg.
module sha2_control (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_write,
	input  logic            in_take,
	input  logic [63:0]     message_word,
	input  logic [3:0]      valid_bytes,
	input  logic            end_of_message,
	input  logic            out_take,
	input  logic [1:0]      variant,
	input  sha2_pkg::stat_t stat,
	input  logic [127:0]    byte_count,
	output sha2_pkg::cmd_t  cmd,
	output logic            idle,
	output logic            out_valid,
	output logic [2:0]      out_index,
	output logic            out_last
);

	sha2_pkg::state_t state_q;
	logic [63:0]  word_q;
	logic [3:0]   left_q;      // bytes of the item still to insert
	logic [2:0]   pos_q;       // next byte lane of the item
	logic         eom_q;
	logic         pad_q;       // padding started (0x80 written)
	logic         spill_q;     // 0x80 landed in the length field: zero fill to block end
	logic         len_done_q;
	logic [127:0] len_q;       // bit length, latched with each item taken
	logic [2:0]   idx_q;
	logic [3:0]   cnt;
	logic [3:0]   nbytes;
	logic         blk_full;
	logic [7:0]   pad_byte;
	logic [3:0]   len_pos;     // byte of the length field being written

	assign nbytes   = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
	assign cnt      = sha2_pkg::digest_words(variant);
	assign blk_full = stat.block_full;
	assign len_pos  = stat.wide ? 4'(stat.fill - 7'd112) : 4'(stat.fill - 7'd56);

	always_comb begin
		if (!pad_q) pad_byte = 8'h80;
		else if (spill_q || stat.fill[6:0] < stat.stop) pad_byte = 8'h00;
		else if (stat.wide) pad_byte = len_q[7'(7'd127 - {len_pos[3:0], 3'b000} - 7'd7) +: 8];
		else pad_byte = len_q[7'(7'd63 - {len_pos[2:0], 3'b000} - 7'd7) +: 8];
	end

	always_comb begin
		cmd = '0;
		cmd.init = cfg_write || (state_q == sha2_pkg::ST_INIT);
		unique case (state_q)
			sha2_pkg::ST_IDLE: begin
				if (in_take) begin
					cmd.count_add = 1'b1;
					cmd.count_n   = nbytes;
				end
			end
			sha2_pkg::ST_LOAD: begin
				if (left_q != 4'd0) begin
					cmd.put_byte = 1'b1;
					cmd.put_val  = word_q[6'd56 - {pos_q, 3'b000} +: 8];
				end else begin
					cmd.put_byte = 1'b1;
					cmd.put_val  = pad_byte;
				end
			end
			sha2_pkg::ST_PAD: begin
				cmd.load = 1'b1;
			end
			sha2_pkg::ST_ROUND: cmd.round = 1'b1;
			sha2_pkg::ST_ADD:   cmd.add = 1'b1;
			sha2_pkg::ST_EMIT, sha2_pkg::ST_INIT: ;
			default: ;
		endcase
	end

	// ST_LOAD writes bytes; on a full block ST_PAD loads the round registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha2_pkg::ST_IDLE;
			left_q  <= '0;
			pos_q   <= '0;
			eom_q   <= 1'b0;
			pad_q   <= 1'b0;
			spill_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				sha2_pkg::ST_IDLE: begin
					if (in_take) begin
						left_q  <= nbytes;
						pos_q   <= '0;
						eom_q   <= end_of_message;
						pad_q   <= 1'b0;
						spill_q <= 1'b0;
						if (nbytes != 4'd0 || end_of_message) state_q <= sha2_pkg::ST_LOAD;
					end
				end
				sha2_pkg::ST_LOAD: begin
					if (left_q != 4'd0) begin
						left_q <= left_q - 4'd1;
						pos_q  <= pos_q + 3'd1;
					end else begin
						pad_q <= 1'b1;
						if (!pad_q && stat.fill >= stat.stop) spill_q <= 1'b1;
					end
					if (blk_full) state_q <= sha2_pkg::ST_PAD;
					else if (left_q == 4'd1 && !eom_q) state_q <= sha2_pkg::ST_IDLE;
				end
				sha2_pkg::ST_PAD: state_q <= sha2_pkg::ST_ROUND;
				sha2_pkg::ST_ROUND: if (stat.last_round) state_q <= sha2_pkg::ST_ADD;
				sha2_pkg::ST_ADD: begin
					spill_q <= 1'b0;
					if (left_q != 4'd0) state_q <= sha2_pkg::ST_LOAD;
					else if (eom_q && pad_q && len_done_q) begin
						state_q <= sha2_pkg::ST_EMIT;
						idx_q   <= '0;
					end else if (eom_q) state_q <= sha2_pkg::ST_LOAD;
					else state_q <= sha2_pkg::ST_IDLE;
				end
				sha2_pkg::ST_EMIT: begin
					if (out_take) begin
						if ({1'b0, idx_q} + 4'd1 == cnt) state_q <= sha2_pkg::ST_INIT;
						idx_q <= idx_q + 3'd1;
					end
				end
				sha2_pkg::ST_INIT: state_q <= sha2_pkg::ST_IDLE;
				default: state_q <= sha2_pkg::ST_IDLE;
			endcase
		end
	end

	// The length field is done once its final byte was written into a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) len_done_q <= 1'b0;
		else if (state_q == sha2_pkg::ST_IDLE) len_done_q <= 1'b0;
		else if (state_q == sha2_pkg::ST_LOAD && left_q == 4'd0 && pad_q && !spill_q
			&& blk_full)
			len_done_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (state_q == sha2_pkg::ST_IDLE && in_take) begin
			word_q <= message_word;
			len_q  <= (byte_count + {124'd0, nbytes}) << 3;
		end
	end

	assign idle      = (state_q == sha2_pkg::ST_IDLE);
	assign out_valid = (state_q == sha2_pkg::ST_EMIT);
	assign out_index = idx_q;
	assign out_last  = ({1'b0, idx_q} + 4'd1 == cnt);

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha2_pkg::ST_EMIT && !out_take) |=> state_q == sha2_pkg::ST_EMIT)
		else $error("digest output dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round |-> !cmd.put_byte)
		else $error("byte written during a round");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha2_pkg::ST_ADD) |-> $past(state_q == sha2_pkg::ST_ROUND))
		else $error("chain update without rounds");

endmodule

// ===== hdl/sha2_family_hash_engine_core.sv =====
// Top level of the SHA-2 hash engine (SHA-224/256/384/512).
// Instantiates sha2_control and sha2_datapath; uses sha2_pkg.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-------------------------------------
//  input    | in_valid / in_ready             | message_word, valid_bytes, end_of_message
//  output   | out_valid / out_ready           | digest_word, word_index, last_word
//  config   | cfg_valid / cfg_ready           | cfg_data (variant)
//
// An item is taken only while idle; its valid bytes are then written one per cycle. A
// full block then loads the round registers and runs one round per cycle in the
// shared round unit before the chain update. A final item adds the padding bytes one
// per cycle, their blocks, then one digest word per cycle while out_ready is high, and
// a reload of the initial values.
// Reset loads the SHA-256 initial values; no clearing pass is needed.
module sha2_family_hash_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] message_word,
	input  logic [3:0]  valid_bytes,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);

	logic [1:0] variant_q;
	sha2_pkg::cmd_t  cmd;
	sha2_pkg::stat_t stat;
	logic [127:0] byte_count;
	logic idle, cfg_write, in_take, out_take;

	// Configuration is accepted only while idle; a pending write holds off input items.
	assign cfg_ready = idle;
	assign cfg_write = cfg_valid && cfg_ready;
	assign in_ready  = idle && !cfg_valid;
	assign in_take   = in_valid && in_ready;
	assign out_take  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) variant_q <= sha2_pkg::VarSha256;
		else if (cfg_write) variant_q <= cfg_data;
	end

	// The datapath reloads with the variant in effect after the write.
	logic [1:0] eff_variant;
	assign eff_variant = cfg_write ? cfg_data : variant_q;

	sha2_control u_ctrl (
		.clk, .arst_n, .cfg_write, .in_take, .message_word, .valid_bytes,
		.end_of_message, .out_take, .variant(variant_q), .stat, .byte_count,
		.cmd, .idle, .out_valid, .out_index(word_index), .out_last(last_word)
	);

	sha2_datapath u_dp (
		.clk, .arst_n, .variant(eff_variant), .cmd, .rd_index(word_index),
		.stat, .byte_count, .rd_word(digest_word)
	);

endmodule

// ===== bench/sha2_family_hash_engine_core_tb.sv =====
// Self-checking testbench of the SHA-2 hash engine core in all four variants.
// Needs sha2_pkg (variant codes, round and initial constants) and the core itself.
module sha2_family_hash_engine_core_tb;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        eom;
	} msg_item_t;

	typedef struct {
		logic [63:0] digest;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] message_word = '0;
	logic [3:0]  valid_bytes = '0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = sha2_pkg::VarSha256;

	sha2_family_hash_engine_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.message_word(message_word), .valid_bytes(valid_bytes),
		.end_of_message(end_of_message),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// The settle pause covers a compression that an item without end may still start.
	localparam int SettleCycles = 200;

	msg_item_t    pending_items[$];
	digest_word_t digest_queue[$];
	int           mismatches = 0;
	bit           no_idle = 1'b0;

	// Predictor state: variant, chaining value, block buffer, fill and the byte count.
	logic [1:0]   hash_variant;
	logic [63:0]  chain[8];
	logic [63:0]  block_buf[16];
	int unsigned  block_fill;
	logic [63:0]  byte_cnt_lo, byte_cnt_hi;

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [63:0] ror64(logic [63:0] x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic is_wide();
		return hash_variant == sha2_pkg::VarSha384 || hash_variant == sha2_pkg::VarSha512;
	endfunction

	task automatic restart_hash();
		for (int i = 0; i < 8; i++) begin
			case (hash_variant)
				sha2_pkg::VarSha224: chain[i] = {32'd0, sha2_pkg::IV384[i][31:0]};
				sha2_pkg::VarSha256: chain[i] = {32'd0, sha2_pkg::IV512[i][63:32]};
				sha2_pkg::VarSha384: chain[i] = sha2_pkg::IV384[i];
				default:             chain[i] = sha2_pkg::IV512[i];
			endcase
		end
		block_fill = 0;
		byte_cnt_lo = '0;
		byte_cnt_hi = '0;
	endtask

	task automatic compress_narrow();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2, a, e;
		for (int t = 0; t < 16; t++)
			w[t] = (t % 2 == 0) ? block_buf[t / 2][63:32] : block_buf[t / 2][31:0];
		for (int t = 16; t < 64; t++)
			w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
				+ (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		for (int t = 0; t < 8; t++)
			v[t] = chain[t][31:0];
		for (int r = 0; r < 64; r++) begin
			a = v[0];
			e = v[4];
			t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + (v[6] ^ (e & (v[5] ^ v[6])))
				+ sha2_pkg::RK[r][63:32] + w[r];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & v[1]) | (v[2] & (a | v[1])));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int t = 0; t < 8; t++)
			chain[t] = {32'd0, chain[t][31:0] + v[t]};
	endtask

	task automatic compress_wide();
		logic [63:0] w[80];
		logic [63:0] v[8];
		logic [63:0] t1, t2, a, e;
		for (int t = 0; t < 16; t++)
			w[t] = block_buf[t];
		for (int t = 16; t < 80; t++)
			w[t] = (ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
				+ (ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
		for (int t = 0; t < 8; t++)
			v[t] = chain[t];
		for (int r = 0; r < 80; r++) begin
			a = v[0];
			e = v[4];
			t1 = v[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + (v[6] ^ (e & (v[5] ^ v[6])))
				+ sha2_pkg::RK[r] + w[r];
			t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & v[1]) | (v[2] & (a | v[1])));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int t = 0; t < 8; t++)
			chain[t] = chain[t] + v[t];
	endtask

	// One byte into the block buffer; a full block is compressed at once.
	task automatic absorb_byte(logic [7:0] b);
		int unsigned pos;
		pos = block_fill;
		block_buf[pos / 8][56 - 8 * (pos % 8) +: 8] = b;
		pos++;
		if (pos >= (is_wide() ? 128 : 64)) begin
			if (is_wide())
				compress_wide();
			else
				compress_narrow();
			pos = 0;
		end
		block_fill = pos;
	endtask

	task automatic absorb_word(logic [63:0] x);
		for (int i = 0; i < 8; i++)
			absorb_byte(x[63 - 8 * i -: 8]);
	endtask

	// Works out the digest words that one accepted item causes, if any.
	task automatic hash_item(msg_item_t it);
		int unsigned n, count, stop;
		logic [63:0] len_lo, len_hi;
		digest_word_t d;
		n = (it.nbytes > 8) ? 8 : it.nbytes;
		for (int i = 0; i < n; i++)
			absorb_byte(it.word[63 - 8 * i -: 8]);
		byte_cnt_lo = byte_cnt_lo + n;
		if (byte_cnt_lo < n)
			byte_cnt_hi = byte_cnt_hi + 1;
		if (it.eom) begin
			len_lo = byte_cnt_lo << 3;
			len_hi = {byte_cnt_hi[60:0], byte_cnt_lo[63:61]};
			stop = is_wide() ? 112 : 56;
			absorb_byte(8'h80);
			while (block_fill != stop)
				absorb_byte(8'h00);
			if (is_wide())
				absorb_word(len_hi);
			absorb_word(len_lo);
			case (hash_variant)
				sha2_pkg::VarSha224: count = 7;
				sha2_pkg::VarSha384: count = 6;
				default:             count = 8;
			endcase
			for (int i = 0; i < count; i++) begin
				d.digest = chain[i];
				d.index = i[2:0];
				d.last = (i + 1 == count);
				digest_queue.push_back(d);
			end
			restart_hash();
		end
	endtask

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %h, expected %h", field, got, want);
		mismatches++;
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	// Driver: the item on the bus is handed to the predictor at the edge that takes it.
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				hash_item('{message_word, valid_bytes, end_of_message});
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					msg_item_t it;
					it = pending_items.pop_front();
					message_word <= it.word;
					valid_bytes <= it.nbytes;
					end_of_message <= it.eom;
					in_valid <= 1'b1;
					in_gap <= idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every digest word taken is checked against the oldest expectation.
	int out_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (digest_queue.size() == 0) begin
					report("unexpected word", digest_word, '0);
				end else begin
					digest_word_t d;
					d = digest_queue.pop_front();
					if (digest_word !== d.digest)
						report("digest_word", digest_word, d.digest);
					if (word_index !== d.index)
						report("word_index", word_index, d.index);
					if (last_word !== d.last)
						report("last_word", last_word, d.last);
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_gap <= idle_len();
			end
		end
	end

	task automatic add_item(logic [63:0] w, logic [3:0] n, logic e);
		pending_items.push_back('{w, n, e});
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// A message of whole eight-byte items with a short tail.
	task automatic add_message(int nfull, logic [3:0] tail);
		for (int i = 0; i < nfull; i++)
			add_item(rand64(), 4'd8, 1'b0);
		add_item(rand64(), tail, 1'b1);
	endtask

	// Random message: mostly full items, some short, oversized or empty ones.
	task automatic add_random_message(int nitems);
		int r;
		logic [3:0] n;
		for (int i = 0; i < nitems; i++) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				n = 4'd8;
			else if (r < 88)
				n = 4'($urandom_range(1, 7));
			else if (r < 95)
				n = 4'($urandom_range(9, 15));
			else
				n = 4'd0;
			add_item(rand64(), n, i == nitems - 1);
		end
	endtask

	// Lets everything queued drain, then pauses for any block still in compression.
	task automatic wait_idle();
		while (pending_items.size() > 0 || in_valid || digest_queue.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_variant(logic [1:0] v);
		wait_idle();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		hash_variant = v;
		restart_hash();
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int len;
		hash_variant = sha2_pkg::VarSha256;
		restart_hash();
		for (int i = 0; i < 16; i++)
			block_buf[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset variant: the empty message, a three-byte
		// message with junk past the valid bytes, an ignored empty item, an
		// oversized byte count, and all-ones and all-zero words.
		add_item(64'h0, 4'd0, 1'b1);
		add_item(64'h616263_FFFFFFFFFF, 4'd3, 1'b1);
		add_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
		add_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0);
		add_item(64'h0, 4'd8, 1'b1);
		// A partial message is abandoned by rewriting the same variant.
		add_item(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
		write_variant(sha2_pkg::VarSha256);
		// Padding just fits (55 bytes) and just spills over (56 bytes).
		write_variant(sha2_pkg::VarSha224);
		add_message(6, 4'd7);
		add_message(7, 4'd0);
		write_variant(sha2_pkg::VarSha384);
		add_message(13, 4'd7);
		write_variant(sha2_pkg::VarSha512);
		add_message(14, 4'd0);
		add_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);

		// Random part: one phase per variant and then random ones; odd phases
		// run without any idling on either side.
		for (int phase = 0; phase < 8; phase++) begin
			write_variant(phase < 4 ? phase[1:0] : 2'($urandom_range(0, 3)));
			no_idle = phase[0];
			for (int m = 0; m < 6; m++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 34)
					: $urandom_range(1, 5);
				add_random_message(len);
			end
		end

		wait_idle();
		if (mismatches == 0 && digest_queue.size() == 0)
			$display("PASS sha2_family_hash_engine_core");
		else
			$display("FAIL sha2_family_hash_engine_core");
		$finish;
	end

	initial begin
		#30000000;
		$display("FAIL sha2_family_hash_engine_core");
		$finish;
	end

endmodule
